/* hdl/http_request_byte_parser_macros.svh */
// -----------------------------------------------------------------------------
// http_request_byte_parser_macros
// Assertion macros used by the checker of the request parser.
// -----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_BYTE_PARSER_MACROS_SVH
`define HTTP_REQUEST_BYTE_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define HRBP_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define HRBP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/hrbp_pkg.sv */
// -----------------------------------------------------------------------------
// hrbp_pkg
// Types, codes and character tables of the HTTP request byte parser.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrbp_pkg;

	// default width of the content length registers
	localparam int LENGTH_WIDTH = 32;
	// a method longer than this ends at the next byte
	localparam logic [3:0] MAX_METHOD_BYTES = 4'd8;

	localparam int NUM_METHODS = 9;
	localparam int NUM_VERSIONS = 2;
	localparam logic [4:0] VERSION_CHARS = 5'd8;
	localparam logic [4:0] LENGTH_NAME_CHARS = 5'd14;
	localparam int BODY_LENGTH_W = 32;

	// result beat width and padded tdata width
	localparam int OUT_BITS = 52;
	localparam int OUT_TDATA_W = 56;

	// parse phases
	typedef enum logic [3:0] {
		PH_METHOD,
		PH_TARGET,
		PH_VERSION,
		PH_FIRST_LF,
		PH_NAME,
		PH_SPACE,
		PH_VALUE,
		PH_LINE_LF,
		PH_FINAL_LF,
		PH_BODY,
		PH_DONE
	} phase_t;

	// request outcome
	typedef enum logic [1:0] {
		OUT_BUSY     = 2'd0,
		OUT_COMPLETE = 2'd1,
		OUT_BAD_METH = 2'd2,
		OUT_EARLY    = 2'd3
	} outcome_t;

	// byte classes
	localparam logic [2:0] CLS_METHOD  = 3'd0;
	localparam logic [2:0] CLS_TARGET  = 3'd1;
	localparam logic [2:0] CLS_VERSION = 3'd2;
	localparam logic [2:0] CLS_NAME    = 3'd3;
	localparam logic [2:0] CLS_VALUE   = 3'd4;
	localparam logic [2:0] CLS_BODY    = 3'd5;
	localparam logic [2:0] CLS_DELIM   = 3'd6;
	localparam logic [2:0] CLS_IGNORED = 3'd7;

	// version codes
	localparam logic [1:0] VER_NONE = 2'd0;
	localparam logic [1:0] VER_1_0  = 2'd1;
	localparam logic [1:0] VER_1_1  = 2'd2;

	// special characters
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// one result beat, first field in the high bits
	typedef struct packed {
		logic       finished;
		outcome_t   outcome;
		logic [31:0] body_length;
		logic [1:0] version_code;
		logic [3:0] method_code;
		logic [2:0] byte_class;
		logic [7:0] byte_out;
	} hrbp_out_t;

	// method name lengths, index 0 is GET
	function automatic logic [3:0] method_len(input logic [3:0] k);
		logic [3:0] n;
		unique case (k)
			4'd0: n = 4'd3;
			4'd1: n = 4'd4;
			4'd2: n = 4'd4;
			4'd3: n = 4'd3;
			4'd4: n = 4'd6;
			4'd5: n = 4'd7;
			4'd6: n = 4'd7;
			4'd7: n = 4'd5;
			4'd8: n = 4'd5;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// method names, left justified in eight bytes
	function automatic logic [63:0] method_text(input logic [3:0] k);
		logic [63:0] s;
		unique case (k)
			4'd0: s = {"GET", 40'h0};
			4'd1: s = {"HEAD", 32'h0};
			4'd2: s = {"POST", 32'h0};
			4'd3: s = {"PUT", 40'h0};
			4'd4: s = {"DELETE", 16'h0};
			4'd5: s = {"CONNECT", 8'h0};
			4'd6: s = {"OPTIONS", 8'h0};
			4'd7: s = {"PATCH", 24'h0};
			4'd8: s = {"TRACE", 24'h0};
			default: s = 64'h0;
		endcase
		return s;
	endfunction

	// character of a method name at a position below eight
	function automatic logic [7:0] method_char(input logic [3:0] k, input logic [2:0] pos);
		logic [63:0] s;
		s = method_text(k) << {pos, 3'b000};
		return s[63:56];
	endfunction

	// character of a version string, index 0 is HTTP/1.0
	function automatic logic [7:0] version_char(input logic k, input logic [2:0] pos);
		logic [63:0] s;
		s = (k ? {"HTTP/1.", "1"} : {"HTTP/1.", "0"}) << {pos, 3'b000};
		return s[63:56];
	endfunction

	// character of the content length header name
	function automatic logic [7:0] length_name_char(input logic [3:0] pos);
		logic [111:0] s;
		s = "Content-Length";
		s = s << {pos, 3'b000};
		return s[111:104];
	endfunction

endpackage

/* hdl/hrbp_engine.sv */
// -----------------------------------------------------------------------------
// hrbp_engine
// Parse state of one request and the per-byte next-state and tagging logic.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrbp_engine #(
	parameter int LENGTH_WIDTH = hrbp_pkg::LENGTH_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                end_of_request,
	output hrbp_pkg::hrbp_out_t result
);
	import hrbp_pkg::*;

	localparam int LW = LENGTH_WIDTH;

	// parse state
	phase_t          phase_q, phase_n;
	logic [3:0]      mlen_q, mlen_n;
	logic [8:0]      mcand_q, mcand_n;
	logic [1:0]      vcand_q, vcand_n;
	logic [4:0]      tpos_q, tpos_n;
	logic            name_len_q, name_len_n;
	logic [LW-1:0]   acc_q, acc_n;
	logic [LW-1:0]   lval_q, lval_n;
	logic [LW-1:0]   brem_q, brem_n;
	outcome_t        res_q, res_n;
	logic [3:0]      hmeth_q, hmeth_n;
	logic [1:0]      hver_q, hver_n;
	logic            dstop_q, dstop_n;
	logic            hdone_q, hdone_n;

	logic [2:0]      cls;
	logic            fin;
	logic [LW+3:0]   acc_x10;
	logic [31:0]     blen_sat;
	logic [4:0]      tpos_bump;

	// times ten plus digit, as shifts and adds
	assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {{(LW-4){1'b0}}, data_byte - CH_ZERO};
	assign tpos_bump = (tpos_q == 5'd31) ? tpos_q : tpos_q + 5'd1;

	// next state for one byte
	always_comb begin
		phase_n    = phase_q;
		mlen_n     = mlen_q;
		mcand_n    = mcand_q;
		vcand_n    = vcand_q;
		tpos_n     = tpos_q;
		name_len_n = name_len_q;
		acc_n      = acc_q;
		lval_n     = lval_q;
		brem_n     = brem_q;
		res_n      = res_q;
		hmeth_n    = hmeth_q;
		hver_n     = hver_q;
		dstop_n    = dstop_q;
		hdone_n    = hdone_q;
		cls        = CLS_DELIM;
		fin        = 1'b0;

		unique case (phase_q)
			PH_METHOD: begin
				if (data_byte == CH_SP || mlen_q > MAX_METHOD_BYTES) begin
					hmeth_n = 4'd0;
					for (int k = 0; k < NUM_METHODS; k++) begin
						if (mcand_q[k] && method_len(4'(k)) == mlen_q)
							hmeth_n = 4'(k + 1);
					end
					if (hmeth_n == 4'd0) begin
						res_n   = OUT_BAD_METH;
						phase_n = PH_DONE;
						fin     = 1'b1;
					end else begin
						phase_n = PH_TARGET;
					end
				end else begin
					cls = CLS_METHOD;
					for (int k = 0; k < NUM_METHODS; k++) begin
						if (mlen_q >= method_len(4'(k))
								|| method_char(4'(k), mlen_q[2:0]) != data_byte)
							mcand_n[k] = 1'b0;
					end
					if (mlen_q != 4'd15)
						mlen_n = mlen_q + 4'd1;
				end
			end
			PH_TARGET: begin
				if (data_byte == CH_SP)
					phase_n = PH_VERSION;
				else
					cls = CLS_TARGET;
			end
			PH_VERSION: begin
				if (data_byte == CH_CR) begin
					hver_n = VER_NONE;
					if (tpos_q == VERSION_CHARS) begin
						if (vcand_q[1])
							hver_n = VER_1_1;
						else if (vcand_q[0])
							hver_n = VER_1_0;
					end
					tpos_n  = 5'd0;
					phase_n = PH_FIRST_LF;
				end else begin
					cls = CLS_VERSION;
					for (int k = 0; k < NUM_VERSIONS; k++) begin
						if (tpos_q >= VERSION_CHARS
								|| version_char(k[0], tpos_q[2:0]) != data_byte)
							vcand_n[k] = 1'b0;
					end
					tpos_n = tpos_bump;
				end
			end
			PH_FIRST_LF, PH_LINE_LF: begin
				if (data_byte == CH_LF) begin
					phase_n    = PH_NAME;
					tpos_n     = 5'd0;
					name_len_n = 1'b1;
				end
			end
			PH_NAME: begin
				if (data_byte == CH_CR) begin
					phase_n = PH_FINAL_LF;
				end else if (data_byte == CH_COLON) begin
					name_len_n = name_len_q && tpos_q == LENGTH_NAME_CHARS;
					tpos_n     = 5'd0;
					acc_n      = '0;
					dstop_n    = 1'b0;
					phase_n    = PH_SPACE;
				end else begin
					cls = CLS_NAME;
					if (tpos_q >= LENGTH_NAME_CHARS
							|| length_name_char(tpos_q[3:0]) != data_byte)
						name_len_n = 1'b0;
					tpos_n = tpos_bump;
				end
			end
			PH_SPACE, PH_VALUE: begin
				// leading blanks and high bytes are skipped before the value
				if (phase_q == PH_SPACE && (data_byte <= CH_SP || data_byte[7])) begin
					cls = CLS_DELIM;
				end else if (phase_q == PH_VALUE && data_byte == CH_CR) begin
					if (name_len_q)
						lval_n = acc_q;
					phase_n = PH_LINE_LF;
				end else begin
					phase_n = PH_VALUE;
					cls     = CLS_VALUE;
					if (!dstop_q) begin
						if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
							if (|acc_x10[LW+3:LW])
								acc_n = '1;
							else
								acc_n = acc_x10[LW-1:0];
						end else if (!(data_byte == CH_PLUS && tpos_q == 5'd0)) begin
							dstop_n = 1'b1;
						end
					end
					tpos_n = tpos_bump;
				end
			end
			PH_FINAL_LF: begin
				if (data_byte == CH_LF) begin
					hdone_n = 1'b1;
					if (lval_q == '0) begin
						res_n   = OUT_COMPLETE;
						phase_n = PH_DONE;
						fin     = 1'b1;
					end else begin
						brem_n  = lval_q;
						phase_n = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				cls    = CLS_BODY;
				brem_n = brem_q - {{(LW-1){1'b0}}, brem_q != '0};
				if (brem_q <= {{(LW-1){1'b0}}, 1'b1}) begin
					res_n   = OUT_COMPLETE;
					phase_n = PH_DONE;
					fin     = 1'b1;
				end
			end
			default: begin
				cls = CLS_IGNORED;
			end
		endcase

		// request cut short before an outcome
		if (end_of_request && res_n == OUT_BUSY) begin
			res_n   = OUT_EARLY;
			phase_n = PH_DONE;
			fin     = 1'b1;
		end
	end

	// fit the content length to the 32-bit result field, saturating a wider one
	generate
		if (LW > BODY_LENGTH_W) begin : g_sat
			assign blen_sat = (|lval_n[LW-1:BODY_LENGTH_W]) ? '1 : lval_n[BODY_LENGTH_W-1:0];
		end else if (LW == BODY_LENGTH_W) begin : g_same
			assign blen_sat = lval_n;
		end else begin : g_ext
			assign blen_sat = {{(BODY_LENGTH_W-LW){1'b0}}, lval_n};
		end
	endgenerate

	// result beat for the byte
	always_comb begin
		result.byte_out     = data_byte;
		result.byte_class   = cls;
		result.method_code  = hmeth_n;
		result.version_code = hver_n;
		result.body_length  = hdone_n ? blen_sat : '0;
		result.outcome      = res_n;
		result.finished     = fin;
	end

	// state registers, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_METHOD;
			mlen_q     <= '0;
			mcand_q    <= '1;
			vcand_q    <= '1;
			tpos_q     <= '0;
			name_len_q <= 1'b1;
			acc_q      <= '0;
			lval_q     <= '0;
			brem_q     <= '0;
			res_q      <= OUT_BUSY;
			hmeth_q    <= '0;
			hver_q     <= '0;
			dstop_q    <= 1'b0;
			hdone_q    <= 1'b0;
		end else if (step) begin
			if (end_of_request) begin
				phase_q    <= PH_METHOD;
				mlen_q     <= '0;
				mcand_q    <= '1;
				vcand_q    <= '1;
				tpos_q     <= '0;
				name_len_q <= 1'b1;
				acc_q      <= '0;
				lval_q     <= '0;
				brem_q     <= '0;
				res_q      <= OUT_BUSY;
				hmeth_q    <= '0;
				hver_q     <= '0;
				dstop_q    <= 1'b0;
				hdone_q    <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				mlen_q     <= mlen_n;
				mcand_q    <= mcand_n;
				vcand_q    <= vcand_n;
				tpos_q     <= tpos_n;
				name_len_q <= name_len_n;
				acc_q      <= acc_n;
				lval_q     <= lval_n;
				brem_q     <= brem_n;
				res_q      <= res_n;
				hmeth_q    <= hmeth_n;
				hver_q     <= hver_n;
				dstop_q    <= dstop_n;
				hdone_q    <= hdone_n;
			end
		end
	end

endmodule

/* hdl/http_request_byte_parser.sv */
// -----------------------------------------------------------------------------
// http_request_byte_parser
// Tags each byte of an HTTP request and reports method, version, length
// and outcome.
// -----------------------------------------------------------------------------
// Input stream: one request byte per beat in s_axis_tdata, s_axis_tlast on
// the final byte of a request; the parser returns to its start state after
// that beat.
// Output stream: one result beat per input beat, in order, with the byte,
// its class, the method and version codes, the content length once the
// headers are done, the outcome and a flag on the byte that settles it.
// Registers: the input register holds the byte, the result register its
// result beat; the per-byte step lies between them.
// Throughput: one byte per cycle when not stalled; the whole per-byte step is
// one pass of character compares and one decimal multiply-accumulate.
// Stalls: when m_axis_tready is low the result register holds and one more
// byte waits in the input register; s_axis_tready drops only while both
// registers are full and the output is stalled.
// Reset: arst_n clears the valid flags of both registers and the parse state.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_request_byte_parser #(
	parameter int LENGTH_WIDTH = hrbp_pkg::LENGTH_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// data_byte
	input  logic [7:0]                     s_axis_tdata,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// byte_out, byte_class, method_code, version_code, body_length, outcome,
	// finished, zero pad
	output logic [hrbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import hrbp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       valid_s2;
	hrbp_out_t  res_s2;
	hrbp_out_t  res_comb;
	logic       adv_s2;
	logic       step;

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// per-byte parse step
	hrbp_engine #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.data_byte     (byte_s1),
		.end_of_request(last_s1),
		.result        (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_comb;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, res_s2};

endmodule

/* hdl/hrbp_checker.sv */
// -----------------------------------------------------------------------------
// hrbp_checker
// Port-level checks of the request parser, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "http_request_byte_parser_macros.svh"

module hrbp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [7:0]                     s_axis_tdata,
	input logic                           s_axis_tlast,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [hrbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import hrbp_pkg::*;

	hrbp_out_t o;
	logic      out_beat;
	logic      in_beat;

	assign o        = m_axis_tdata[OUT_BITS-1:0];
	assign out_beat = m_axis_tvalid && m_axis_tready;
	assign in_beat  = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
		&& (s_axis_tlast == s_axis_tlast);

	// a stalled result beat holds
	`HRBP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result beat changed")

	// input back-pressure only comes from a stalled output
	`HRBP_ASSERT_IMPLY(a_ready_cause, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready && (in_beat == 1'b0), "input stalled without output stall")

	// the settling beat carries a settled outcome
	`HRBP_ASSERT_IMPLY(a_fin_outcome, clk, arst_n, out_beat && o.finished, o.outcome != OUT_BUSY, "finished with outcome in progress")

	// bytes after finish are never settling and carry a settled outcome
	`HRBP_ASSERT_IMPLY(a_ignored, clk, arst_n, out_beat && o.byte_class == CLS_IGNORED, !o.finished && o.outcome != OUT_BUSY, "ignored byte with open outcome")

	// method bytes come before any version or length
	`HRBP_ASSERT_IMPLY(a_method_first, clk, arst_n, out_beat && o.byte_class == CLS_METHOD, o.version_code == VER_NONE && o.body_length == '0, "method byte after version")

endmodule

bind http_request_byte_parser hrbp_checker u_hrbp_checker (.*);
